/* rtl/crt_pkg.sv */
// ---------------------------------------------------------------------------
// crt_pkg : shared types and constants for the chunk request tracker
// Item and result layouts, opcodes, status codes, table geometry and small
// helpers for the per-row status search.
// ---------------------------------------------------------------------------
package crt_pkg;

	// table geometry: status kept as rows of 16 two-bit entries
	localparam int MAX_CHUNKS = 4096;
	localparam int SEQ_W      = $clog2(MAX_CHUNKS);
	localparam int ROW_ENT    = 16;
	localparam int ENT_W      = $clog2(ROW_ENT);
	localparam int STAT_W     = 2;
	localparam int ROW_DW     = ROW_ENT * STAT_W;
	localparam int ROWS       = MAX_CHUNKS / ROW_ENT;
	localparam int ROW_AW     = $clog2(ROWS);
	localparam int GRP_ENT    = 16;
	localparam int GROUPS     = ROWS / GRP_ENT;
	localparam int GRP_W      = $clog2(GROUPS);
	localparam int CNT_W      = SEQ_W + 1;

	localparam int TIME_W     = 32;
	localparam int MS_W       = 16;
	localparam int Q_W        = 24;
	localparam int LIFE_Q_W   = 27;
	localparam int LIFE_W     = 19;
	localparam int DVD_W      = 31;

	localparam logic [Q_W-1:0]      MIN_DEV_Q   = 24'd1280;
	localparam logic [LIFE_Q_W-1:0] MIN_LIFE_Q  = 27'd2560;
	localparam logic [LIFE_W-1:0]   MIN_LIFE_MS = 19'd10;

	localparam logic [MS_W-1:0] RESET_PAYLOAD  = 16'd1400;
	localparam logic [MS_W-1:0] RESET_MAX_RTT  = 16'd500;
	localparam logic [MS_W-1:0] RESET_INIT_RTT = 16'd500;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_RTT = 2'd2;

	localparam logic [2:0] OP_MREQ    = 3'd0;
	localparam logic [2:0] OP_MDATA   = 3'd1;
	localparam logic [2:0] OP_REQNEXT = 3'd2;
	localparam logic [2:0] OP_CDATA   = 3'd3;
	localparam logic [2:0] OP_TMO     = 3'd4;

	localparam logic [STAT_W-1:0] ST_NOT_REQ = 2'd0;
	localparam logic [STAT_W-1:0] ST_REQ     = 2'd1;
	localparam logic [STAT_W-1:0] ST_RCVD    = 2'd2;
	localparam logic [STAT_W-1:0] ST_TMO     = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISP,
		S_DIV,
		S_SCAN,
		S_MOD,
		S_DEV,
		S_FIN
	} fsm_t;

	typedef struct packed {
		logic [2:0]        operation;
		logic [SEQ_W-1:0]  sequence_number;
		logic [TIME_W-1:0] now_ms;
		logic signed [31:0] file_size;
	} item_t;

	typedef struct packed {
		logic              issue_request;
		logic [SEQ_W-1:0]  request_sequence;
		logic [LIFE_W-1:0] lifetime_ms;
		logic              is_retransmission;
		logic              all_received;
		logic              file_error;
		logic              resend_manifest;
		logic              timed_out;
		logic [MS_W-1:0]   estimated_rtt_ms;
	} result_t;

	// commands to the estimator; when several are set, the first field wins
	typedef struct packed {
		logic load_init;
		logic load_manifest;
		logic chunk_est;
		logic chunk_dev;
		logic timeout;
	} est_ctl_t;

	// entries of a row that lie at or below the last chunk index
	function automatic logic [ROW_ENT-1:0] row_mask(input logic [ROW_AW-1:0] row,
			input logic [SEQ_W-1:0] last);
		logic [ROW_ENT-1:0] m;
		for (int k = 0; k < ROW_ENT; k++) begin
			m[k] = (row < last[SEQ_W-1:ENT_W]) ||
				((row == last[SEQ_W-1:ENT_W]) && (ENT_W'(k) <= last[ENT_W-1:0]));
		end
		return m;
	endfunction

	// entries still to request: never requested or timed out
	function automatic logic [ROW_ENT-1:0] pend_bits(input logic [ROW_DW-1:0] data,
			input logic [ROW_ENT-1:0] mask);
		logic [ROW_ENT-1:0] p;
		for (int k = 0; k < ROW_ENT; k++) begin
			p[k] = mask[k] && ((data[k*STAT_W +: STAT_W] == ST_NOT_REQ) ||
				(data[k*STAT_W +: STAT_W] == ST_TMO));
		end
		return p;
	endfunction

	function automatic logic [ENT_W-1:0] first_idx(input logic [ROW_ENT-1:0] bits);
		logic [ENT_W-1:0] idx;
		idx = '0;
		for (int k = ROW_ENT - 1; k >= 0; k--) begin
			if (bits[k]) begin
				idx = ENT_W'(k);
			end
		end
		return idx;
	endfunction

endpackage

/* rtl/crt_ram.sv */
// ---------------------------------------------------------------------------
// crt_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module crt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/crt_div.sv */
// ---------------------------------------------------------------------------
// crt_div : restoring divider, one quotient bit per cycle
// Divides the file size by the payload size; done pulses with the quotient.
// ---------------------------------------------------------------------------
module crt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [crt_pkg::DVD_W-1:0]   dividend,
	input  logic [crt_pkg::MS_W-1:0]    divisor,
	output logic                        done,
	output logic [crt_pkg::DVD_W-1:0]   quot
);

	localparam int CNT_W = $clog2(crt_pkg::DVD_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [crt_pkg::DVD_W-1:0]   dvd_q;
	logic [crt_pkg::MS_W-1:0]    dvs_q;
	logic [crt_pkg::MS_W-1:0]    rem_q;
	logic [crt_pkg::MS_W:0]      trial;
	logic                        fits;

	assign trial = {rem_q, dvd_q[crt_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(crt_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? crt_pkg::MS_W'(trial - {1'b0, dvs_q}) : trial[crt_pkg::MS_W-1:0];
			dvd_q <= {dvd_q[crt_pkg::DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;

endmodule

/* rtl/crt_est.sv */
// ---------------------------------------------------------------------------
// crt_est : round trip estimate and deviation, unsigned Q16.8
// Sample saturation, smoothed estimate, deviation and timeout back-off.
// ---------------------------------------------------------------------------
module crt_est (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crt_pkg::est_ctl_t             ctl,
	input  logic [crt_pkg::MS_W-1:0]      cfg_rtt,
	input  logic [crt_pkg::MS_W-1:0]      max_rtt,
	input  logic [crt_pkg::TIME_W-1:0]    now_ms,
	input  logic [crt_pkg::TIME_W-1:0]    then_ms,
	output logic [crt_pkg::Q_W-1:0]       est,
	output logic [crt_pkg::LIFE_Q_W-1:0]  life_q
);

	logic [crt_pkg::Q_W-1:0]    est_q;
	logic [crt_pkg::Q_W-1:0]    dev_q;
	logic [crt_pkg::Q_W-1:0]    sq_s1;
	logic [crt_pkg::TIME_W-1:0] delta;
	logic [crt_pkg::MS_W-1:0]   sample;
	logic [crt_pkg::Q_W-1:0]    sq;
	logic [crt_pkg::Q_W+1:0]    est_sum;
	logic [crt_pkg::Q_W-1:0]    diff;
	logic [crt_pkg::Q_W-1:0]    diff_min;
	logic [crt_pkg::Q_W+2:0]    dev_sum;
	logic [crt_pkg::Q_W:0]      est2;
	logic [crt_pkg::Q_W:0]      cap;

	assign delta   = now_ms - then_ms;
	assign sample  = (|delta[crt_pkg::TIME_W-1:crt_pkg::MS_W]) ? '1 : delta[crt_pkg::MS_W-1:0];
	assign sq      = {sample, 8'h00};
	// 3*est + sample, then /4
	assign est_sum = {2'b00, est_q} + {1'b0, est_q, 1'b0} + {2'b00, sq};
	assign diff    = (sq_s1 > est_q) ? sq_s1 - est_q : est_q - sq_s1;
	assign diff_min = (diff < crt_pkg::MIN_DEV_Q) ? crt_pkg::MIN_DEV_Q : diff;
	// 7*dev + diff, then /8
	assign dev_sum = {dev_q, 3'b000} - {3'b000, dev_q} + {3'b000, diff_min};
	assign est2    = {est_q, 1'b0};
	assign cap     = {1'b0, max_rtt, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= {crt_pkg::RESET_INIT_RTT, 8'h00};
			dev_q <= '0;
			sq_s1 <= '0;
		end else begin
			priority if (ctl.load_init) begin
				est_q <= {cfg_rtt, 8'h00};
				dev_q <= '0;
			end else if (ctl.load_manifest) begin
				est_q <= sq;
				dev_q <= {1'b0, sample[crt_pkg::MS_W-1:1], 8'h00};
			end else if (ctl.chunk_est) begin
				est_q <= est_sum[crt_pkg::Q_W+1:2];
				sq_s1 <= sq;
			end else if (ctl.chunk_dev) begin
				dev_q <= dev_sum[crt_pkg::Q_W+2:3];
			end else if (ctl.timeout) begin
				est_q <= (est2 > cap) ? cap[crt_pkg::Q_W-1:0] : est2[crt_pkg::Q_W-1:0];
			end
		end
	end

	assign est    = est_q;
	assign life_q = {3'b000, est_q} + {1'b0, dev_q, 2'b00};

endmodule

/* rtl/chunk_request_tracker_with_rto.sv */
// ---------------------------------------------------------------------------
// chunk_request_tracker_with_rto : download chunk tracker with RTO estimate
// Keeps per-chunk status and send time in RAM, picks the next chunk to
// request, and keeps a Jacobson/Karels style round trip estimate.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake            beat carries
//  item      in   item_valid/stall     operation, sequence_number, now_ms, file_size
//  result    out  result_valid/stall   one result_t per item
//  cfg       in   cfg_valid/ready      cfg_index, cfg_data (16 bits)
//
// States per item: manifest_request, unknown codes and any rejected or ignored
// event pass DISP and FIN; timeout adds MOD; chunk_data adds MOD and DEV;
// request_next scans one summary group of 16 rows per cycle (16 groups), then
// MOD when a chunk is issued; manifest_data waits in DIV on the 31-step serial
// divider. After reset a clearing pass writes all 256 status rows with
// item_stall held high; cfg writes are taken throughout (cfg_ready is tied high).
// One item is in flight at a time; the next is taken while its result beat still
// waits in the output register, and a held result only delays the following one.
//
// Status RAM: 256 rows x 16 entries x 2 bits. Send-time RAM: 4096 x 32 bits.
// A 256-bit row summary (row has a chunk still to request) drives the search.
// ---------------------------------------------------------------------------
module chunk_request_tracker_with_rto (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  crt_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output crt_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [crt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crt_pkg::MS_W-1:0]          cfg_data
);

	crt_pkg::fsm_t                      state_q, state_d;
	crt_pkg::item_t                     item_q;
	crt_pkg::result_t                   res_q;
	crt_pkg::result_t                   fin_res;
	crt_pkg::result_t                   out_q;
	logic                               out_valid_q;

	logic [crt_pkg::MS_W-1:0]           pay_q;
	logic [crt_pkg::MS_W-1:0]           max_rtt_q;
	logic                               mr_q;       // manifest received
	logic                               fp_q;       // file present
	logic [crt_pkg::SEQ_W-1:0]          last_q;
	logic [crt_pkg::TIME_W-1:0]         mrt_q;      // manifest request time
	logic [crt_pkg::CNT_W-1:0]          rcvd_q;
	logic [crt_pkg::ROWS-1:0]           summary_q;
	logic [crt_pkg::ROW_AW-1:0]         row_q;
	logic [crt_pkg::GRP_W-1:0]          grp_q;
	logic [crt_pkg::ROW_AW-1:0]         clr_q;

	// RAM ports
	logic                               stat_we, stat_re;
	logic [crt_pkg::ROW_AW-1:0]         stat_waddr, stat_raddr;
	logic [crt_pkg::ROW_DW-1:0]         stat_wdata, stat_rdata;
	logic                               send_we, send_re;
	logic [crt_pkg::SEQ_W-1:0]          send_waddr, send_raddr;
	logic [crt_pkg::TIME_W-1:0]         send_rdata;

	logic                               div_start, div_done;
	logic [crt_pkg::DVD_W-1:0]          div_quot;
	logic [crt_pkg::MS_W-1:0]           pay_eff;

	crt_pkg::est_ctl_t                  est_ctl;
	logic [crt_pkg::Q_W-1:0]            est;
	logic [crt_pkg::LIFE_Q_W-1:0]       life_q;
	logic [crt_pkg::TIME_W-1:0]         then_ms;

	logic                               accept;
	logic                               slot_free;
	logic                               valid_idx;
	logic [crt_pkg::GRP_ENT-1:0]        grp_bits;
	logic [crt_pkg::ROW_AW-1:0]         found_row;
	logic [crt_pkg::ROW_ENT-1:0]        mask;
	logic [crt_pkg::ENT_W-1:0]          k_sel;
	logic [crt_pkg::ENT_W:0]            k_bit;
	logic [crt_pkg::STAT_W-1:0]         old_stat, new_stat;
	logic [crt_pkg::ROW_DW-1:0]         new_row;
	logic                               new_pend;
	logic                               all_rcvd;
	logic                               div_err;

	assign accept    = item_valid && !item_stall;
	assign slot_free = !out_valid_q || !result_stall;
	assign valid_idx = mr_q && fp_q && (item_q.sequence_number <= last_q);
	assign pay_eff   = (pay_q == '0) ? crt_pkg::MS_W'(1) : pay_q;
	assign div_err   = |div_quot[crt_pkg::DVD_W-1:crt_pkg::SEQ_W];
	assign all_rcvd  = mr_q && fp_q && (rcvd_q == ({1'b0, last_q} + crt_pkg::CNT_W'(1)));

	// search: one group of row summary bits per cycle
	assign grp_bits  = summary_q[{grp_q, {crt_pkg::ENT_W{1'b0}}} +: crt_pkg::GRP_ENT];
	assign found_row = {grp_q, crt_pkg::first_idx(grp_bits)};

	// row modify
	assign mask     = crt_pkg::row_mask(row_q, last_q);
	assign k_sel    = (item_q.operation == crt_pkg::OP_REQNEXT) ?
		crt_pkg::first_idx(crt_pkg::pend_bits(stat_rdata, mask)) :
		item_q.sequence_number[crt_pkg::ENT_W-1:0];
	assign k_bit    = {k_sel, 1'b0};
	assign old_stat = stat_rdata[k_bit +: crt_pkg::STAT_W];

	always_comb begin
		unique case (item_q.operation)
			crt_pkg::OP_REQNEXT: new_stat = crt_pkg::ST_REQ;
			crt_pkg::OP_CDATA:   new_stat = crt_pkg::ST_RCVD;
			default:             new_stat = crt_pkg::ST_TMO;
		endcase
		new_row = stat_rdata;
		new_row[k_bit +: crt_pkg::STAT_W] = new_stat;
	end
	assign new_pend = |crt_pkg::pend_bits(new_row, mask);

	assign then_ms = (state_q == crt_pkg::S_MOD) ? send_rdata : mrt_q;

	// result beat as it leaves: status after the event
	always_comb begin
		fin_res                  = res_q;
		fin_res.all_received     = all_rcvd;
		fin_res.estimated_rtt_ms = est[crt_pkg::Q_W-1:8];
	end

	// next state and strobes
	always_comb begin
		state_d    = state_q;
		stat_we    = 1'b0;
		stat_waddr = row_q;
		stat_wdata = new_row;
		stat_re    = 1'b0;
		stat_raddr = item_q.sequence_number[crt_pkg::SEQ_W-1:crt_pkg::ENT_W];
		send_we    = 1'b0;
		send_waddr = {row_q, k_sel};
		send_re    = 1'b0;
		send_raddr = item_q.sequence_number;
		div_start  = 1'b0;
		est_ctl    = '0;
		est_ctl.load_init = cfg_valid && (cfg_index == crt_pkg::CFG_INIT_RTT);
		item_stall = (state_q != crt_pkg::S_IDLE);
		unique case (state_q)
			crt_pkg::S_CLEAR: begin
				stat_we    = 1'b1;
				stat_waddr = clr_q;
				stat_wdata = '0;
				if (clr_q == crt_pkg::ROW_AW'(crt_pkg::ROWS - 1)) begin
					state_d = crt_pkg::S_IDLE;
				end
			end
			crt_pkg::S_IDLE: begin
				if (accept) begin
					state_d = crt_pkg::S_DISP;
				end
			end
			crt_pkg::S_DISP: begin
				state_d = crt_pkg::S_FIN;
				unique case (item_q.operation)
					crt_pkg::OP_MDATA: begin
						if (!mr_q && !item_q.file_size[31]) begin
							div_start = 1'b1;
							state_d   = crt_pkg::S_DIV;
						end
					end
					crt_pkg::OP_REQNEXT: begin
						if (mr_q && fp_q) begin
							state_d = crt_pkg::S_SCAN;
						end
					end
					crt_pkg::OP_CDATA: begin
						if (valid_idx) begin
							stat_re = 1'b1;
							send_re = 1'b1;
							state_d = crt_pkg::S_MOD;
						end
					end
					crt_pkg::OP_TMO: begin
						if ((mr_q || item_q.sequence_number != '0) && valid_idx) begin
							stat_re = 1'b1;
							state_d = crt_pkg::S_MOD;
						end
					end
					default: begin
					end
				endcase
			end
			crt_pkg::S_DIV: begin
				if (div_done) begin
					est_ctl.load_manifest = !div_err;
					state_d = crt_pkg::S_FIN;
				end
			end
			crt_pkg::S_SCAN: begin
				if (|grp_bits) begin
					stat_re    = 1'b1;
					stat_raddr = found_row;
					state_d    = crt_pkg::S_MOD;
				end else if (grp_q == crt_pkg::GRP_W'(crt_pkg::GROUPS - 1)) begin
					state_d = crt_pkg::S_FIN;
				end
			end
			crt_pkg::S_MOD: begin
				state_d = crt_pkg::S_FIN;
				unique case (item_q.operation)
					crt_pkg::OP_REQNEXT: begin
						stat_we = 1'b1;
						send_we = 1'b1;
					end
					crt_pkg::OP_CDATA: begin
						stat_we           = 1'b1;
						est_ctl.chunk_est = 1'b1;
						state_d           = crt_pkg::S_DEV;
					end
					default: begin
						if (old_stat != crt_pkg::ST_RCVD) begin
							stat_we         = 1'b1;
							est_ctl.timeout = 1'b1;
						end
					end
				endcase
			end
			crt_pkg::S_DEV: begin
				est_ctl.chunk_dev = 1'b1;
				state_d           = crt_pkg::S_FIN;
			end
			crt_pkg::S_FIN: begin
				if (slot_free) begin
					state_d = crt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = crt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crt_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pay_q       <= crt_pkg::RESET_PAYLOAD;
			max_rtt_q   <= crt_pkg::RESET_MAX_RTT;
			mr_q        <= 1'b0;
			fp_q        <= 1'b0;
			last_q      <= '0;
			mrt_q       <= '0;
			rcvd_q      <= '0;
			summary_q   <= '0;
			grp_q       <= '0;
			clr_q       <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					crt_pkg::CFG_PAYLOAD: pay_q     <= cfg_data;
					crt_pkg::CFG_MAX_RTT: max_rtt_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == crt_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == crt_pkg::S_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == crt_pkg::S_DISP) begin
				grp_q <= '0;
				unique case (item_q.operation)
					crt_pkg::OP_MREQ: mrt_q <= item_q.now_ms;
					crt_pkg::OP_MDATA: begin
						if (!mr_q && item_q.file_size[31]) begin
							mr_q   <= 1'b1;
							fp_q   <= 1'b0;
							last_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == crt_pkg::S_SCAN) begin
				grp_q <= grp_q + 1'b1;
			end
			if (state_q == crt_pkg::S_DIV && div_done) begin
				mr_q <= 1'b1;
				if (div_err) begin
					fp_q   <= 1'b0;
					last_q <= '0;
				end else begin
					fp_q   <= (item_q.file_size != '0);
					last_q <= div_quot[crt_pkg::SEQ_W-1:0];
					// every row up to the last one holds unrequested chunks
					for (int r = 0; r < crt_pkg::ROWS; r++) begin
						summary_q[r] <= crt_pkg::ROW_AW'(r) <=
							div_quot[crt_pkg::SEQ_W-1:crt_pkg::ENT_W];
					end
				end
			end
			if (state_q == crt_pkg::S_MOD && stat_we) begin
				summary_q[row_q] <= new_pend;
				if (item_q.operation == crt_pkg::OP_CDATA && old_stat != crt_pkg::ST_RCVD) begin
					rcvd_q <= rcvd_q + 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			res_q  <= '0;
		end
		if (state_q == crt_pkg::S_DISP) begin
			unique case (item_q.operation)
				crt_pkg::OP_MREQ: res_q.lifetime_ms <= life_q[crt_pkg::LIFE_Q_W-1:8];
				crt_pkg::OP_MDATA: res_q.file_error <= !mr_q && item_q.file_size[31];
				crt_pkg::OP_CDATA: res_q.file_error <= !valid_idx;
				crt_pkg::OP_TMO: begin
					res_q.resend_manifest <= !mr_q && (item_q.sequence_number == '0);
					res_q.file_error <= (mr_q || item_q.sequence_number != '0) && !valid_idx;
				end
				default: begin
				end
			endcase
		end
		if (state_q == crt_pkg::S_DIV && div_done) begin
			res_q.file_error <= div_err;
		end
		if (state_q == crt_pkg::S_SCAN) begin
			row_q <= found_row;
		end else if (state_q == crt_pkg::S_DISP) begin
			row_q <= item_q.sequence_number[crt_pkg::SEQ_W-1:crt_pkg::ENT_W];
		end
		if (state_q == crt_pkg::S_MOD) begin
			if (item_q.operation == crt_pkg::OP_REQNEXT) begin
				res_q.issue_request     <= 1'b1;
				res_q.request_sequence  <= {row_q, k_sel};
				res_q.is_retransmission <= (old_stat == crt_pkg::ST_TMO);
				res_q.lifetime_ms <= (life_q < crt_pkg::MIN_LIFE_Q) ? crt_pkg::MIN_LIFE_MS :
					life_q[crt_pkg::LIFE_Q_W-1:8];
			end else if (item_q.operation == crt_pkg::OP_TMO) begin
				res_q.timed_out <= (old_stat != crt_pkg::ST_RCVD);
			end
		end
		if (state_q == crt_pkg::S_FIN && slot_free) begin
			out_q <= fin_res;
		end
	end

	crt_ram #(
		.WIDTH (crt_pkg::ROW_DW),
		.DEPTH (crt_pkg::ROWS)
	) u_stat_ram (
		.clk   (clk),
		.we    (stat_we),
		.waddr (stat_waddr),
		.wdata (stat_wdata),
		.re    (stat_re),
		.raddr (stat_raddr),
		.rdata (stat_rdata)
	);

	crt_ram #(
		.WIDTH (crt_pkg::TIME_W),
		.DEPTH (crt_pkg::MAX_CHUNKS)
	) u_send_ram (
		.clk   (clk),
		.we    (send_we),
		.waddr (send_waddr),
		.wdata (item_q.now_ms),
		.re    (send_re),
		.raddr (send_raddr),
		.rdata (send_rdata)
	);

	crt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (item_q.file_size[crt_pkg::DVD_W-1:0]),
		.divisor  (pay_eff),
		.done     (div_done),
		.quot     (div_quot)
	);

	crt_est u_est (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (est_ctl),
		.cfg_rtt (cfg_data),
		.max_rtt (max_rtt_q),
		.now_ms  (item_q.now_ms),
		.then_ms (then_ms),
		.est     (est),
		.life_q  (life_q)
	);

	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* rtl/crt_check.sv */
// ---------------------------------------------------------------------------
// crt_check : port-level checks for the chunk request tracker
// Watches the result channel and item intake; bound to the top level.
// ---------------------------------------------------------------------------
module crt_check (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input crt_pkg::result_t result
);

	// held result beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// one item in flight: busy right after intake
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while previous one in flight");

	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.issue_request |->
			result.lifetime_ms >= crt_pkg::MIN_LIFE_MS && !result.file_error &&
			!result.timed_out && !result.resend_manifest)
		else $error("issued request with bad lifetime or flags");

	a_resend: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.resend_manifest |->
			!result.all_received && !result.file_error && !result.timed_out)
		else $error("manifest resend alongside other status");

endmodule

bind chunk_request_tracker_with_rto crt_check u_crt_check (.*);
